[sv/nbbc_pkg.sv]
// nbbc_pkg: payload structs, action codes, sequencer states and fixed sizes
// for the histogram base caller. No dependencies.
package nbbc_pkg;

    localparam int NFEAT     = 8;
    localparam int CLASSES   = 4;
    localparam int FRAC_BITS = 16;

    typedef enum logic [1:0] {
        ACT_RANGE    = 2'd0,
        ACT_TRAIN    = 2'd1,
        ACT_CLASSIFY = 2'd2,
        ACT_CLEAR    = 2'd3
    } t_action;

    typedef struct packed {
        t_action     action;
        logic [15:0] a_signal;
        logic [15:0] c_signal;
        logic [15:0] g_signal;
        logic [15:0] t_signal;
        logic [15:0] a_noise;
        logic [15:0] c_noise;
        logic [15:0] g_noise;
        logic [15:0] t_noise;
    } t_nbbc_in;

    typedef struct packed {
        logic [1:0]  called_base;
        logic        no_call;
        logic [15:0] error_fraction;
    } t_nbbc_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_BIN_GO,
        S_BIN_WAIT,
        S_TRN_RD,
        S_TRN_LAT,
        S_TRN_WR,
        S_CLS_INIT,
        S_CLS_RD,
        S_CLS_LAT,
        S_CLS_MUL,
        S_CLS_SUM,
        S_CLS_END,
        S_DIV,
        S_PUSH
    } t_state;

    typedef struct packed {
        logic start;
        logic done;
    } t_bin_ctl;

endpackage

[sv/nbbc_count_ram.sv]
// nbbc_count_ram: single-port synchronous store for the bin counts,
// registered read data. No package dependency.
module nbbc_count_ram #(
    parameter int DW    = 16,
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[sv/nbbc_binner.sv]
// nbbc_binner: bins one feature value against its range with a
// bit-per-cycle restoring divider. Uses nbbc_pkg.
module nbbc_binner #(
    parameter int BINS        = 15,
    parameter int SAMPLE_BITS = 16,
    parameter int BIN_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nbbc_pkg::t_bin_ctl     i_ctl,
    output nbbc_pkg::t_bin_ctl     o_ctl,
    input  logic [SAMPLE_BITS-1:0] i_x,
    input  logic [SAMPLE_BITS-1:0] i_lo,
    input  logic [SAMPLE_BITS-1:0] i_hi,
    output logic [BIN_W-1:0]       o_bin
);
    import nbbc_pkg::*;

    localparam int NW = SAMPLE_BITS + BIN_W;
    localparam int KW = $clog2(BIN_W + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [KW-1:0] r_step, n_step;
    logic [NW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_den, n_den;
    logic [BIN_W-1:0] r_q, n_q;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_den  = r_den;
        n_q    = r_q;
        if (i_ctl.start) begin
            if (i_x <= i_lo) begin
                n_q    = '0;
                n_done = 1'b1;
            end else if (i_x >= i_hi) begin
                n_q    = BIN_W'(BINS);
                n_done = 1'b1;
            end else begin
                n_busy = 1'b1;
                n_rem  = NW'(i_x - i_lo) * NW'(BINS);
                n_den  = NW'(i_hi - i_lo) << (BIN_W - 1);
                n_step = KW'(BIN_W - 1);
                n_q    = '0;
            end
        end else if (r_busy) begin
            if (r_rem >= r_den) begin
                n_rem = r_rem - r_den;
                n_q   = BIN_W'({r_q, 1'b1});
            end else begin
                n_q   = BIN_W'({r_q, 1'b0});
            end
            n_den = r_den >> 1;
            n_step = r_step - KW'(1);
            if (r_step == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
    end

    assign o_ctl.start = r_busy;
    assign o_ctl.done  = r_done;
    assign o_bin       = r_q;
endmodule

[sv/naive_bayes_base_caller_unit.sv]
// naive_bayes_base_caller_unit: top level, sequencer, range and class
// registers, score multiplier and fraction divider.
// Depends on nbbc_pkg, nbbc_count_ram and nbbc_binner.
//
// One item at a time. Each train or classify item first bins its eight
// features; a value at or past an edge of its range skips the divider. Train
// then does a read-modify-write per feature. Classify reads the 32 counts
// from the count memory one at a time and multiplies each into the class
// score with a shift-add unit, then runs the fraction divider. After reset
// and after a clear item the count memory is swept to zero, during which no
// item is taken.
module naive_bayes_base_caller_unit #(
    parameter int BINS        = 15,
    parameter int COUNT_BITS  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  nbbc_pkg::t_nbbc_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output nbbc_pkg::t_nbbc_out o_out_data
);
    import nbbc_pkg::*;

    localparam int NBIN  = BINS + 1;
    localparam int BIN_W = $clog2(NBIN);
    localparam int DEPTH = NFEAT * NBIN * CLASSES;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = (NFEAT + 1) * COUNT_BITS;
    localparam int TW    = SW + 2;
    localparam int CW    = $clog2(COUNT_BITS);
    localparam int DCW   = $clog2(FRAC_BITS);

    t_state r_state, n_state;

    logic [SAMPLE_BITS-1:0] r_lo [NFEAT];
    logic [SAMPLE_BITS-1:0] r_hi [NFEAT];
    logic [SAMPLE_BITS-1:0] n_lo [NFEAT];
    logic [SAMPLE_BITS-1:0] n_hi [NFEAT];
    logic                   r_started, n_started;
    logic [COUNT_BITS-1:0]  r_cc [CLASSES];
    logic [COUNT_BITS-1:0]  n_cc [CLASSES];
    logic [AW-1:0]          r_addr, n_addr;
    logic                   r_out_valid, n_out_valid;

    logic [SAMPLE_BITS-1:0] r_x [NFEAT];
    logic [SAMPLE_BITS-1:0] x_in [NFEAT];
    logic [BIN_W-1:0]       r_bins [NFEAT];
    logic                   r_train, n_train;
    logic [1:0]             r_label, n_label;
    logic [2:0]             r_f, n_f;
    logic [1:0]             r_k, n_k;
    logic [CW-1:0]          r_bit, n_bit;
    logic [SW-1:0]          r_score, n_score;
    logic [SW-1:0]          r_acc, n_acc;
    logic [SW-1:0]          r_best, n_best;
    logic [1:0]             r_bestk, n_bestk;
    logic [TW-1:0]          r_total, n_total;
    logic [TW-1:0]          r_rem, n_rem;
    logic [FRAC_BITS-1:0]   r_frac, n_frac;
    logic [DCW-1:0]         r_dcnt, n_dcnt;
    logic                   r_nocall, n_nocall;
    t_nbbc_out              r_out, n_out;

    logic                  we;
    logic [COUNT_BITS-1:0] wdata, rdata;
    t_bin_ctl              bin_req, bin_stat;
    logic [BIN_W-1:0]      bin_val;
    logic                  accept;
    logic [1:0]            lab;
    logic [TW:0]           rem2;
    logic [AW-1:0]         feat_addr;

    nbbc_count_ram #(.DW(COUNT_BITS), .DEPTH(DEPTH), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(r_addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    nbbc_binner #(.BINS(BINS), .SAMPLE_BITS(SAMPLE_BITS), .BIN_W(BIN_W)) u_bin (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(bin_req), .o_ctl(bin_stat),
        .i_x(r_x[r_f]), .i_lo(r_lo[r_f]), .i_hi(r_hi[r_f]), .o_bin(bin_val)
    );

    always_comb begin
        logic [16+SAMPLE_BITS-1:0] e [NFEAT];
        e[0] = {SAMPLE_BITS'(0), i_in_data.a_signal};
        e[1] = {SAMPLE_BITS'(0), i_in_data.c_signal};
        e[2] = {SAMPLE_BITS'(0), i_in_data.g_signal};
        e[3] = {SAMPLE_BITS'(0), i_in_data.t_signal};
        e[4] = {SAMPLE_BITS'(0), i_in_data.a_noise};
        e[5] = {SAMPLE_BITS'(0), i_in_data.c_noise};
        e[6] = {SAMPLE_BITS'(0), i_in_data.g_noise};
        e[7] = {SAMPLE_BITS'(0), i_in_data.t_noise};
        for (int i = 0; i < NFEAT; i++) begin
            x_in[i] = e[i][SAMPLE_BITS-1:0];
        end
        lab = 2'd0;
        for (int k = 1; k < 4; k++) begin
            if (x_in[k] > x_in[lab]) begin
                lab = 2'(k);
            end
        end
    end

    assign accept    = i_in_valid && o_in_ready;
    assign rem2      = {r_rem, 1'b0};
    assign feat_addr = AW'((int'(r_f) * NBIN + int'(r_bins[r_f])) * CLASSES
                           + int'(r_train ? r_label : r_k));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:    if (r_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.action)
                        ACT_CLEAR:                n_state = S_CLEAR;
                        ACT_TRAIN, ACT_CLASSIFY:  n_state = S_BIN_GO;
                        default:                  n_state = S_IDLE;
                    endcase
                end
            end
            S_BIN_GO:   n_state = S_BIN_WAIT;
            S_BIN_WAIT: begin
                if (bin_stat.done) begin
                    if (r_f != 3'(NFEAT - 1)) n_state = S_BIN_GO;
                    else if (r_train)         n_state = S_TRN_RD;
                    else                      n_state = S_CLS_INIT;
                end
            end
            S_TRN_RD:   n_state = S_TRN_LAT;
            S_TRN_LAT:  n_state = S_TRN_WR;
            S_TRN_WR:   n_state = (r_f == 3'(NFEAT - 1)) ? S_IDLE : S_TRN_RD;
            S_CLS_INIT: n_state = S_CLS_RD;
            S_CLS_RD:   n_state = S_CLS_LAT;
            S_CLS_LAT:  n_state = S_CLS_MUL;
            S_CLS_MUL: begin
                if (r_bit == '0) begin
                    n_state = (r_f == 3'(NFEAT - 1)) ? S_CLS_SUM : S_CLS_RD;
                end
            end
            S_CLS_SUM:  n_state = (r_k == 2'(CLASSES - 1)) ? S_CLS_END : S_CLS_INIT;
            S_CLS_END:  n_state = (r_total == '0) ? S_PUSH : S_DIV;
            S_DIV:      if (r_dcnt == DCW'(FRAC_BITS - 1)) n_state = S_PUSH;
            S_PUSH:     if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        bin_req.start = (r_state == S_BIN_GO);
        bin_req.done  = 1'b0;
        we            = (r_state == S_CLEAR) || (r_state == S_TRN_WR);
        wdata         = '0;
        if (r_state == S_TRN_WR) begin
            wdata = (rdata == '1) ? rdata : rdata + COUNT_BITS'(1);
        end
    end

    // datapath
    always_comb begin
        n_lo = r_lo; n_hi = r_hi; n_started = r_started; n_cc = r_cc;
        n_addr = r_addr; n_train = r_train; n_label = r_label;
        n_f = r_f; n_k = r_k; n_bit = r_bit; n_score = r_score; n_acc = r_acc;
        n_best = r_best; n_bestk = r_bestk; n_total = r_total; n_rem = r_rem;
        n_frac = r_frac; n_dcnt = r_dcnt; n_nocall = r_nocall; n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_CLEAR: n_addr = r_addr + AW'(1);
            S_IDLE: begin
                if (accept) begin
                    n_f     = '0;
                    n_label = lab;
                    n_train = (i_in_data.action == ACT_TRAIN);
                    case (i_in_data.action)
                        ACT_CLEAR: begin
                            n_addr    = '0;
                            n_started = 1'b0;
                            for (int i = 0; i < NFEAT; i++) begin
                                n_lo[i] = '0;
                                n_hi[i] = '0;
                            end
                            for (int k = 0; k < CLASSES; k++) n_cc[k] = '0;
                        end
                        ACT_RANGE: begin
                            n_started = 1'b1;
                            for (int i = 0; i < NFEAT; i++) begin
                                if (!r_started) begin
                                    n_lo[i] = x_in[i];
                                    n_hi[i] = x_in[i];
                                end else begin
                                    if (x_in[i] > r_hi[i]) n_hi[i] = x_in[i];
                                    if (x_in[i] < r_lo[i]) n_lo[i] = x_in[i];
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_BIN_WAIT: begin
                if (bin_stat.done) begin
                    n_f = r_f + 3'd1;
                    if (r_f == 3'(NFEAT - 1)) begin
                        n_k     = '0;
                        n_total = '0;
                    end
                end
            end
            S_TRN_RD, S_CLS_RD: n_addr = feat_addr;
            S_TRN_WR: begin
                n_f = r_f + 3'd1;
                if (r_f == 3'(NFEAT - 1) && r_cc[r_label] != '1) begin
                    n_cc[r_label] = r_cc[r_label] + COUNT_BITS'(1);
                end
            end
            S_CLS_INIT: begin
                n_score = SW'(r_cc[r_k]);
                n_f     = '0;
            end
            S_CLS_LAT: begin
                n_acc = '0;
                n_bit = CW'(COUNT_BITS - 1);
            end
            S_CLS_MUL: begin
                n_acc = SW'(r_acc << 1) + (rdata[r_bit] ? r_score : SW'(0));
                n_bit = r_bit - CW'(1);
                if (r_bit == '0) begin
                    n_score = n_acc;
                    n_f     = r_f + 3'd1;
                end
            end
            S_CLS_SUM: begin
                n_total = r_total + TW'(r_score);
                if (r_k == '0 || r_score > r_best) begin
                    n_best  = r_score;
                    n_bestk = r_k;
                end
                n_k = r_k + 2'd1;
            end
            S_CLS_END: begin
                n_nocall = (r_total == '0);
                n_rem    = r_total - TW'(r_best);
                n_frac   = '0;
                n_dcnt   = '0;
            end
            S_DIV: begin
                n_dcnt = r_dcnt + DCW'(1);
                if (rem2 >= {1'b0, r_total}) begin
                    n_rem  = TW'(rem2 - {1'b0, r_total});
                    n_frac = {r_frac[FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_rem  = TW'(rem2);
                    n_frac = {r_frac[FRAC_BITS-2:0], 1'b0};
                end
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.no_call        = r_nocall;
                    n_out.called_base    = r_nocall ? 2'd0 : r_bestk;
                    n_out.error_fraction = r_nocall ? 16'd0 : r_frac;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NFEAT; i++) begin
                r_lo[i] <= '0;
                r_hi[i] <= '0;
            end
            for (int k = 0; k < CLASSES; k++) r_cc[k] <= '0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_started   <= n_started;
            r_out_valid <= n_out_valid;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
            r_cc        <= n_cc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_x <= x_in;
        if (r_state == S_BIN_WAIT && bin_stat.done) r_bins[r_f] <= bin_val;
        r_train <= n_train; r_label <= n_label; r_f <= n_f; r_k <= n_k;
        r_bit <= n_bit; r_score <= n_score; r_acc <= n_acc; r_best <= n_best;
        r_bestk <= n_bestk; r_total <= n_total; r_rem <= n_rem;
        r_frac <= n_frac; r_dcnt <= n_dcnt; r_nocall <= n_nocall; r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_in_ready)
        else $error("item taken during count sweep");
    a_we_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_state == S_CLEAR || r_state == S_TRN_WR))
        else $error("count write outside sweep or train");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_total))
        else $error("fraction remainder out of bound");
    a_nocall_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.no_call) |->
        (o_out_data.error_fraction == 16'd0 && o_out_data.called_base == 2'd0))
        else $error("no-call result carries data");
`endif
endmodule
